@@ rtl/csvt_pkg.sv @@
`default_nettype none

package csvt_pkg;

   // Field counting saturates here; the count register is seven bits wide.
   localparam int MAX_COLUMNS = 64;
   localparam logic [6:0] COL_CAP = (MAX_COLUMNS < 127) ? 7'(MAX_COLUMNS) : 7'd127;

   // Column register value after reset.
   localparam logic [6:0] DEFAULT_COLUMNS = 7'd6;

   // Characters with a meaning to the parser.
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   // Error codes reported on the result channel.
   localparam logic [2:0] ERR_MISPLACED_QUOTE = 3'd0;
   localparam logic [2:0] ERR_JUNK_AFTER_QUOTE = 3'd1;
   localparam logic [2:0] ERR_UNTERMINATED     = 3'd2;
   localparam logic [2:0] ERR_COLUMN_COUNT     = 3'd3;
   localparam logic [2:0] ERR_NO_RECORD        = 3'd4;

   // Depth of the result queue; it must hold two results beyond one in flight.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last;
   } req_type;

   typedef struct packed {
      logic       has_char;
      logic [7:0] char_out;
      logic       field_end;
      logic       record_end;
      logic [6:0] column_index;
      logic       error;
      logic [2:0] error_code;
      logic       run_last;
   } rsp_type;

   // Results of one byte: how many are valid (0 to 2) and the two slots.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } step_out_type;

endpackage

`default_nettype wire

@@ rtl/csvt_step.sv @@
`default_nettype none

module csvt_step (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire csvt_pkg::req_type     item,
   input  wire logic [6:0]            expected_columns,
   output csvt_pkg::step_out_type     step_out
);
   import csvt_pkg::*;

   localparam logic [2:0] MODE_START  = 3'd0;
   localparam logic [2:0] MODE_PLAIN  = 3'd1;
   localparam logic [2:0] MODE_QUOTED = 3'd2;
   localparam logic [2:0] MODE_QPEND  = 3'd3;
   localparam logic [2:0] MODE_HALT   = 3'd4;

   logic [2:0] mode_ff, mode_in;
   logic       crp_ff, crp_in;
   logic [6:0] fields_ff, fields_in;
   logic       seen_ff, seen_in;

   rsp_type    res [2];
   logic [1:0] n;

   function automatic rsp_type make_rsp(logic has, logic [7:0] ch, logic fe, logic re,
                                        logic [6:0] col, logic err, logic [2:0] code);
      rsp_type r;
      r.has_char     = has;
      r.char_out     = ch;
      r.field_end    = fe;
      r.record_end   = re;
      r.column_index = col;
      r.error        = err;
      r.error_code   = code;
      r.run_last     = 1'b0;
      return r;
   endfunction

   // Whole step for one byte: byte handling, then end-of-stream handling.
   always_comb begin
      logic [7:0] b;
      logic       nl;
      logic       go;
      logic       swallow;
      logic       col_bad;
      b        = item.byte_in;
      nl       = (b == CH_LF) || (b == CH_CR);
      go       = 1'b0;
      swallow  = 1'b0;
      col_bad  = 1'b0;
      mode_in   = mode_ff;
      crp_in    = crp_ff;
      fields_in = fields_ff;
      seen_in   = seen_ff;
      n         = 2'd0;
      res[0]    = '0;
      res[1]    = '0;

      if (mode_ff != MODE_HALT) begin
         if (crp_ff) begin
            crp_in  = 1'b0;
            swallow = (b == CH_LF);
         end

         // Byte handling that depends on the current mode.
         if (!swallow) begin
            unique case (mode_ff)
               MODE_QUOTED: begin
                  if (b == CH_QUOTE) begin
                     mode_in = MODE_QPEND;
                  end else begin
                     res[0] = make_rsp(1'b1, b, 1'b0, 1'b0, 7'd0, 1'b0, 3'd0);
                     n      = 2'd1;
                  end
               end
               MODE_QPEND: begin
                  if (b == CH_QUOTE) begin
                     mode_in = MODE_QUOTED;
                     res[0]  = make_rsp(1'b1, b, 1'b0, 1'b0, 7'd0, 1'b0, 3'd0);
                     n       = 2'd1;
                  end else if (!nl && b != CH_COMMA) begin
                     mode_in = MODE_HALT;
                     res[0]  = make_rsp(1'b0, 8'd0, 1'b0, 1'b0, 7'd0, 1'b1,
                                        ERR_JUNK_AFTER_QUOTE);
                     n       = 2'd1;
                  end else begin
                     go = 1'b1;
                  end
               end
               MODE_PLAIN: begin
                  if (b == CH_QUOTE) begin
                     mode_in = MODE_HALT;
                     res[0]  = make_rsp(1'b0, 8'd0, 1'b0, 1'b0, 7'd0, 1'b1,
                                        ERR_MISPLACED_QUOTE);
                     n       = 2'd1;
                  end else begin
                     go = 1'b1;
                  end
               end
               MODE_START: begin
                  if (b == CH_QUOTE) begin
                     mode_in = MODE_QUOTED;
                  end else begin
                     go = 1'b1;
                  end
               end
               default: begin
                  go = 1'b0;
               end
            endcase

            // Separators and plain content.
            if (go) begin
               if (b == CH_COMMA) begin
                  res[0]    = make_rsp(1'b0, 8'd0, 1'b1, 1'b0, fields_ff, 1'b0, 3'd0);
                  n         = 2'd1;
                  fields_in = (fields_ff < COL_CAP) ? fields_ff + 7'd1 : COL_CAP;
                  mode_in   = MODE_START;
               end else if (nl) begin
                  col_bad = (expected_columns != 7'd0) &&
                            ((fields_ff >= COL_CAP) ||
                             ({1'b0, fields_ff} + 8'd1 != {1'b0, expected_columns}));
                  n = 2'd1;
                  if (col_bad) begin
                     mode_in = MODE_HALT;
                     res[0]  = make_rsp(1'b0, 8'd0, 1'b0, 1'b0, 7'd0, 1'b1,
                                        ERR_COLUMN_COUNT);
                  end else begin
                     res[0]    = make_rsp(1'b0, 8'd0, 1'b1, 1'b1, fields_ff, 1'b0, 3'd0);
                     fields_in = 7'd0;
                     seen_in   = 1'b1;
                     mode_in   = MODE_START;
                     if (b == CH_CR) begin
                        crp_in = 1'b1;
                     end
                  end
               end else begin
                  mode_in = MODE_PLAIN;
                  res[0]  = make_rsp(1'b1, b, 1'b0, 1'b0, 7'd0, 1'b0, 3'd0);
                  n       = 2'd1;
               end
            end
         end

         // End of stream: report an open quote, or close an open record and check that one was seen.
         if (item.last && mode_in != MODE_HALT) begin
            if (mode_in == MODE_QUOTED) begin
               mode_in     = MODE_HALT;
               res[n[0]]   = make_rsp(1'b0, 8'd0, 1'b0, 1'b0, 7'd0, 1'b1,
                                      ERR_UNTERMINATED);
               n           = n + 2'd1;
            end else begin
               if (mode_in == MODE_QPEND || mode_in == MODE_PLAIN ||
                   (mode_in == MODE_START && fields_in != 7'd0)) begin
                  col_bad = (expected_columns != 7'd0) &&
                            ((fields_in >= COL_CAP) ||
                             ({1'b0, fields_in} + 8'd1 != {1'b0, expected_columns}));
                  if (col_bad) begin
                     mode_in   = MODE_HALT;
                     res[n[0]] = make_rsp(1'b0, 8'd0, 1'b0, 1'b0, 7'd0, 1'b1,
                                          ERR_COLUMN_COUNT);
                  end else begin
                     res[n[0]] = make_rsp(1'b0, 8'd0, 1'b1, 1'b1, fields_in, 1'b0, 3'd0);
                     fields_in = 7'd0;
                     seen_in   = 1'b1;
                     mode_in   = MODE_START;
                  end
                  n = n + 2'd1;
               end
               if (mode_in != MODE_HALT && !seen_in) begin
                  mode_in   = MODE_HALT;
                  res[n[0]] = make_rsp(1'b0, 8'd0, 1'b0, 1'b0, 7'd0, 1'b1, ERR_NO_RECORD);
                  n         = n + 2'd1;
               end
            end
         end
      end

      // The final byte of a stream leaves the parser ready for the next one.
      if (item.last) begin
         mode_in   = MODE_START;
         crp_in    = 1'b0;
         fields_in = 7'd0;
         seen_in   = 1'b0;
      end

      if (n == 2'd1) begin
         res[0].run_last = 1'b1;
      end else if (n == 2'd2) begin
         res[1].run_last = 1'b1;
      end
   end

   assign step_out.count  = n;
   assign step_out.first  = res[0];
   assign step_out.second = res[1];

   // Parser state advances only when a byte is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_START;
         crp_ff    <= 1'b0;
         fields_ff <= 7'd0;
         seen_ff   <= 1'b0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         crp_ff    <= crp_in;
         fields_ff <= fields_in;
         seen_ff   <= seen_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/csvt_rsp_queue.sv @@
`default_nettype none

module csvt_rsp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire csvt_pkg::step_out_type step_out,
   output logic                       room,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output csvt_pkg::rsp_type          rsp_item
);
   import csvt_pkg::*;

   rsp_type                entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_W:0]     count_ff, count_in;
   logic [1:0]             push_count;
   logic                   pop;

   // Room for the two results a byte may cause.
   assign room       = (count_ff <= (RSP_PTR_W+1)'(RSP_DEPTH - 2));
   assign rsp_valid  = (count_ff != '0);
   assign rsp_item   = entry_ff[rd_ptr_ff];
   assign pop        = rsp_valid && !rsp_stall;
   assign push_count = push ? step_out.count : 2'd0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + (RSP_PTR_W+1)'(push_count) - (RSP_PTR_W+1)'(pop);
   end

   // Queue storage: up to two writes per cycle at consecutive places.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= step_out.first;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= step_out.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/csv_quoted_field_tokenizer_core.sv @@
// CSV tokenizer, one byte of text per transaction on the request channel.
// The request channel carries a byte and a last flag that marks the final
// byte of a stream; the response channel carries field content bytes, field
// and record boundaries with their column index, errors, and a run_last flag
// on the final response caused by each request.
// An accepted request is held in the input register and its results go to
// the response queue. The block takes one request per cycle while the queue
// has room for two results; a byte causes at most one response, and the
// final byte of a stream up to two. The rate is set by the single parsing
// stage between the input register and a four-entry response queue.
// The user must write the expected column count on the csr_ port while the
// block is idle; the block does not enforce this. Zero disables the check.
// Synchronous reset clears the parser to the start of a field outside quotes,
// empties the response queue and sets the expected column count to six.
// When the receiver stalls, responses wait in the queue; once it cannot hold
// two more, the request channel stalls in turn. After an error no responses
// are given until the byte that carries last, which clears the stream state.
`default_nettype none

module csv_quoted_field_tokenizer_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire csvt_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output csvt_pkg::rsp_type      rsp_item,
   input  wire logic              csr_write_enable,
   input  wire logic [6:0]        csr_write_data
);
   import csvt_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_type      in_item_ff;
   logic [6:0]   columns_ff;
   logic         room;
   logic         fire;
   logic         accept;
   step_out_type step_out;

   // Input register advances when the queue can take a whole byte's results.
   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
   end

   // Expected column count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= DEFAULT_COLUMNS;
      end else if (csr_write_enable) begin
         columns_ff <= csr_write_data;
      end
   end

   csvt_step u_step (
      .clock            (clock),
      .reset            (reset),
      .fire             (fire),
      .item             (in_item_ff),
      .expected_columns (columns_ff),
      .step_out         (step_out)
   );

   csvt_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .step_out  (step_out),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

@@ dv/csv_quoted_field_tokenizer_core_tb.sv @@
`default_nettype none

module csv_quoted_field_tokenizer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import csvt_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BYTES  = 200;

   typedef enum logic [2:0] {
      PM_START,
      PM_PLAIN,
      PM_QUOTED,
      PM_QPEND,
      PM_HALT
   } parse_mode_type;

   // Predicts the token stream of the tokenizer and checks what comes out.
   class token_scoreboard;
      logic [6:0]     columns;
      parse_mode_type mode;
      bit             cr_pending;
      logic [6:0]     field_count;
      bit             record_done;
      rsp_type        pending_tokens[$];
      rsp_type        step_tokens[$];
      int             failures;

      function new();
         columns  = DEFAULT_COLUMNS;
         failures = 0;
         clear_stream();
      endfunction

      function void clear_stream();
         mode        = PM_START;
         cr_pending  = 1'b0;
         field_count = '0;
         record_done = 1'b0;
      endfunction

      function void set_columns(logic [6:0] value);
         columns = value;
      endfunction

      function int pending();
         return pending_tokens.size();
      endfunction

      function void emit(bit has, logic [7:0] ch, bit fe, bit re, logic [6:0] col,
                         bit err, logic [2:0] code);
         rsp_type tok;
         tok.has_char     = has;
         tok.char_out     = ch;
         tok.field_end    = fe;
         tok.record_end   = re;
         tok.column_index = col;
         tok.error        = err;
         tok.error_code   = code;
         tok.run_last     = 1'b0;
         step_tokens.push_back(tok);
      endfunction

      function void halt(logic [2:0] code);
         mode = PM_HALT;
         emit(1'b0, 8'h00, 1'b0, 1'b0, 7'd0, 1'b1, code);
      endfunction

      function void close_field();
         emit(1'b0, 8'h00, 1'b1, 1'b0, field_count, 1'b0, 3'd0);
         field_count = (field_count < COL_CAP) ? field_count + 7'd1 : COL_CAP;
         mode = PM_START;
      endfunction

      // A record that fails the column check reports an error in place of its boundary.
      function void close_record();
         if (columns != 0 &&
             (field_count >= COL_CAP || int'(field_count) + 1 != int'(columns))) begin
            halt(ERR_COLUMN_COUNT);
            return;
         end
         emit(1'b0, 8'h00, 1'b1, 1'b1, field_count, 1'b0, 3'd0);
         field_count = '0;
         record_done = 1'b1;
         mode        = PM_START;
      endfunction

      function void parse_byte(logic [7:0] b);
         bit nl;
         nl = (b == CH_LF) || (b == CH_CR);
         case (mode)
            PM_QUOTED: begin
               if (b == CH_QUOTE) begin
                  mode = PM_QPEND;
               end else begin
                  emit(1'b1, b, 1'b0, 1'b0, 7'd0, 1'b0, 3'd0);
               end
               return;
            end
            PM_QPEND: begin
               // A held quote is either an escape or the close of the field; anything else is an error.
               if (b == CH_QUOTE) begin
                  mode = PM_QUOTED;
                  emit(1'b1, b, 1'b0, 1'b0, 7'd0, 1'b0, 3'd0);
                  return;
               end
               if (!nl && b != CH_COMMA) begin
                  halt(ERR_JUNK_AFTER_QUOTE);
                  return;
               end
            end
            PM_PLAIN: begin
               if (b == CH_QUOTE) begin
                  halt(ERR_MISPLACED_QUOTE);
                  return;
               end
            end
            PM_START: begin
               if (b == CH_QUOTE) begin
                  mode = PM_QUOTED;
                  return;
               end
            end
            default: begin
               return;
            end
         endcase

         if (b == CH_COMMA) begin
            close_field();
         end else if (nl) begin
            close_record();
            if (b == CH_CR && mode != PM_HALT) cr_pending = 1'b1;
         end else begin
            mode = PM_PLAIN;
            emit(1'b1, b, 1'b0, 1'b0, 7'd0, 1'b0, 3'd0);
         end
      endfunction

      // End of stream: close what is open, or complain about what is missing.
      function void finish_stream();
         if (mode == PM_QUOTED) begin
            halt(ERR_UNTERMINATED);
            return;
         end
         if (mode == PM_QPEND || mode == PM_PLAIN || (mode == PM_START && field_count != 0))
            close_record();
         if (mode != PM_HALT && !record_done) halt(ERR_NO_RECORD);
      endfunction

      function void note_byte(req_type item);
         bit swallow;
         step_tokens.delete();
         if (mode != PM_HALT) begin
            swallow = 1'b0;
            if (cr_pending) begin
               cr_pending = 1'b0;
               swallow    = (item.byte_in == CH_LF);
            end
            if (!swallow) parse_byte(item.byte_in);
            if (item.last && mode != PM_HALT) finish_stream();
         end
         if (item.last) clear_stream();
         if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].run_last = 1'b1;
         foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_token(rsp_type got);
         rsp_type want;
         if (pending_tokens.size() == 0) begin
            failures++;
            $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
            return;
         end
         want = pending_tokens.pop_front();
         compare_field("has_char", 8'(want.has_char), 8'(got.has_char));
         compare_field("char_out", want.char_out, got.char_out);
         compare_field("field_end", 8'(want.field_end), 8'(got.field_end));
         compare_field("record_end", 8'(want.record_end), 8'(got.record_end));
         compare_field("column_index", 8'(want.column_index), 8'(got.column_index));
         compare_field("error", 8'(want.error), 8'(got.error));
         compare_field("error_code", 8'(want.error_code), 8'(got.error_code));
         compare_field("run_last", 8'(want.run_last), 8'(got.run_last));
      endfunction
   endclass

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   req_type    req_item         = '0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   rsp_type    rsp_item;
   logic       csr_write_enable = 1'b0;
   logic [6:0] csr_write_data   = '0;

   token_scoreboard sb = new();

   logic [7:0] stream_bytes[$];
   logic [6:0] cols_setting = DEFAULT_COLUMNS;
   bit         steady       = 1'b0;
   bit         rsp_steady   = 1'b0;
   int         bytes_sent   = 0;

   csv_quoted_field_tokenizer_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Response side: check each accepted transaction and stall at random outside the steady phases.
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_token(rsp_item);
         if (stall_left == 0 && !rsp_steady && !reset) stall_left = pick_gap();
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("csv_quoted_field_tokenizer_core_tb NOT OK");
      $finish;
   end

   // Offer one byte and hold it until the block takes it.
   task automatic send_byte(logic [7:0] b, bit last);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{byte_in: b, last: last};
      do @(posedge clock); while (req_stall);
      sb.note_byte(req_item);
      bytes_sent++;
   endtask

   task automatic send_stream();
      foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
   endtask

   // Let every expected transaction arrive and the pipeline empty.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_columns(logic [6:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_columns(value);
      cols_setting = value;
   endtask

   // Build one stream of well-formed records, now and then damaged or pure noise.
   task automatic build_stream();
      int         n_rec, n_fld, len, term_len, pick, cut;
      bit         quoted;
      logic [7:0] b;
      stream_bytes.delete();
      if ($urandom_range(0, 15) == 0) begin
         len = $urandom_range(1, 12);
         repeat (len) stream_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      term_len = 0;
      n_rec = $urandom_range(1, 4);
      repeat (n_rec) begin
         if (int'(cols_setting) >= 1 && int'(cols_setting) <= MAX_COLUMNS &&
             $urandom_range(0, 7) != 0)
            n_fld = int'(cols_setting);
         else if ($urandom_range(0, 39) == 0)
            n_fld = $urandom_range(MAX_COLUMNS - 1, MAX_COLUMNS + 6);
         else
            n_fld = $urandom_range(1, 8);
         for (int f = 0; f < n_fld; f++) begin
            if (f > 0) stream_bytes.push_back(CH_COMMA);
            quoted = ($urandom_range(0, 2) == 0);
            len = (n_fld > 8) ? $urandom_range(0, 1) : $urandom_range(0, 4);
            if (quoted) stream_bytes.push_back(CH_QUOTE);
            repeat (len) begin
               if (quoted) begin
                  // Quoted text favours the bytes that would otherwise be special.
                  pick = $urandom_range(0, 7);
                  case (pick)
                     0: b = CH_QUOTE;
                     1: b = CH_COMMA;
                     2: b = CH_CR;
                     3: b = CH_LF;
                     default: b = 8'($urandom_range(0, 255));
                  endcase
                  stream_bytes.push_back(b);
                  if (b == CH_QUOTE) stream_bytes.push_back(CH_QUOTE);
               end else begin
                  do b = 8'($urandom_range(0, 255));
                  while (b == CH_QUOTE || b == CH_COMMA || b == CH_CR || b == CH_LF);
                  stream_bytes.push_back(b);
               end
            end
            if (quoted) stream_bytes.push_back(CH_QUOTE);
         end
         pick = $urandom_range(0, 2);
         if (pick == 0) begin
            stream_bytes.push_back(CH_LF);
            term_len = 1;
         end else if (pick == 1) begin
            stream_bytes.push_back(CH_CR);
            term_len = 1;
         end else begin
            stream_bytes.push_back(CH_CR);
            stream_bytes.push_back(CH_LF);
            term_len = 2;
         end
      end
      // The last record may end with the stream instead of a line end.
      if ($urandom_range(0, 2) == 0 && stream_bytes.size() > term_len)
         repeat (term_len) void'(stream_bytes.pop_back());
      if ($urandom_range(0, 7) == 0)
         stream_bytes[$urandom_range(0, stream_bytes.size() - 1)] =
            ($urandom_range(0, 1) == 0) ? CH_QUOTE : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 15) == 0) begin
         cut = $urandom_range(1, stream_bytes.size());
         while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
      end
   endtask

   initial begin : stimulus
      logic [6:0] col_plan[$];
      int         phase_start;
      bit         paused_once;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed streams with the expected column count set to two.
      write_columns(7'd2);
      // Extreme bytes, an escaped quote, CR LF, then a stray quote on the final byte.
      stream_bytes = '{8'h00, CH_COMMA, CH_QUOTE, 8'hFF, CH_QUOTE, CH_QUOTE, CH_QUOTE,
                       CH_CR, CH_LF, 8'h78, CH_QUOTE};
      send_stream();
      // Junk after a closing quote, then bytes ignored while halted.
      stream_bytes = '{CH_QUOTE, 8'h61, CH_QUOTE, 8'h62, 8'h63, CH_LF};
      send_stream();
      // Quote left open at the end of the stream.
      stream_bytes = '{CH_QUOTE, 8'h71};
      send_stream();
      // A held quote closes the field when the stream ends.
      stream_bytes = '{8'h61, CH_COMMA, CH_QUOTE, CH_QUOTE};
      send_stream();
      // Too few fields in the record.
      stream_bytes = '{8'h61, CH_LF};
      send_stream();

      // Random phases across column settings, extremes included.
      col_plan = '{7'd6, 7'd0, 7'd1, 7'd64, 7'd65, 7'd127};
      col_plan.push_back(7'($urandom_range(0, 127)));
      col_plan.push_back(7'($urandom_range(1, 8)));
      paused_once = 1'b0;
      foreach (col_plan[p]) begin
         write_columns(col_plan[p]);
         steady     = (p % 3 == 2);
         rsp_steady = (p % 3 == 2);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            build_stream();
            send_stream();
            // Hold the sender back until the results have all come out.
            if (!paused_once || $urandom_range(0, 9) == 0) begin
               paused_once = 1'b1;
               req_valid <= 1'b0;
               do @(posedge clock); while (sb.pending() != 0);
            end
         end
      end

      wait_drained();
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("csv_quoted_field_tokenizer_core_tb OK");
      end else begin
         $display("csv_quoted_field_tokenizer_core_tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/csvt_pkg.sv
rtl/csvt_step.sv
rtl/csvt_rsp_queue.sv
rtl/csv_quoted_field_tokenizer_core.sv
dv/csv_quoted_field_tokenizer_core_tb.sv
